// File: rtl/core/tcdd_pkg.sv
// Shared types, command constants and digit encoding for the clock display driver.
package tcdd_pkg;

    localparam int unsigned BRIGHT_W = 3;
    localparam int unsigned DIGITS   = 4;

    localparam logic [7:0] CMD_DATA  = 8'h40;
    localparam logic [7:0] CMD_ADDR  = 8'hC0;
    localparam logic [7:0] CMD_CTRL  = 8'h88;
    localparam logic [7:0] COLON_BIT = 8'h80;

    localparam logic [6:0] VALUE_MAX = 7'd99;

    localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 3'd7;

    localparam logic REG_BRIGHTNESS = 1'b0;
    localparam logic REG_COLON      = 1'b1;

    localparam logic [1:0] ACTION_TIME   = 2'd1;
    localparam logic [1:0] ACTION_BRIGHT = 2'd2;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_TIME,
        ACT_BRIGHT
    } t_act;

    typedef struct packed {
        t_act                       act;
        logic [DIGITS-1:0][7:0]     digits;
        logic [BRIGHT_W-1:0]        bright;
    } t_req;

    function automatic logic [7:0] seg_code(input logic [3:0] d);
        logic [7:0] code;
        unique case (d)
            4'd0:    code = 8'h3f;
            4'd1:    code = 8'h06;
            4'd2:    code = 8'h5b;
            4'd3:    code = 8'h4f;
            4'd4:    code = 8'h66;
            4'd5:    code = 8'h6d;
            4'd6:    code = 8'h7d;
            4'd7:    code = 8'h07;
            4'd8:    code = 8'h7f;
            4'd9:    code = 8'h6f;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

    // Tens digit by multiplying with 205/2048, exact for values up to 99.
    function automatic logic [3:0] tens_of(input logic [6:0] v);
        logic [14:0] prod;
        prod = 15'(v) * 15'd205;
        return prod[14:11];
    endfunction

    function automatic logic [3:0] ones_of(input logic [6:0] v, input logic [3:0] tens);
        logic [6:0] t10;
        t10 = 7'(tens) * 7'd10;
        return 4'(v - t10);
    endfunction

    function automatic logic [6:0] sat_value(input logic [6:0] v);
        return (v > VALUE_MAX) ? VALUE_MAX : v;
    endfunction

endpackage

// File: rtl/core/tcdd_front.sv
// Input stage: holds the configuration, classifies each tick and encodes the digits.
module tcdd_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [tcdd_pkg::BRIGHT_W-1:0] i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_action,
    input  logic [6:0]                    i_hours,
    input  logic [6:0]                    i_minutes,
    output logic                          o_push,
    output tcdd_pkg::t_req                o_req,
    input  logic                          i_q_full
);

    logic [tcdd_pkg::BRIGHT_W-1:0] r_bright;
    logic                          r_colon;
    logic                          r_valid;
    tcdd_pkg::t_req                r_req;
    tcdd_pkg::t_req                n_req;
    logic                          accept;
    logic [6:0]                    h_sat;
    logic [6:0]                    m_sat;
    logic [3:0]                    h_tens;
    logic [3:0]                    m_tens;

    assign o_push     = r_valid && !i_q_full;
    assign o_in_stall = r_valid && i_q_full;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_req      = r_req;

    assign h_sat  = tcdd_pkg::sat_value(i_hours);
    assign m_sat  = tcdd_pkg::sat_value(i_minutes);
    assign h_tens = tcdd_pkg::tens_of(h_sat);
    assign m_tens = tcdd_pkg::tens_of(m_sat);

    always_comb begin
        unique case (i_action)
            tcdd_pkg::ACTION_TIME:   n_req.act = tcdd_pkg::ACT_TIME;
            tcdd_pkg::ACTION_BRIGHT: n_req.act = tcdd_pkg::ACT_BRIGHT;
            default:                 n_req.act = tcdd_pkg::ACT_NONE;
        endcase
        n_req.digits[0] = tcdd_pkg::seg_code(h_tens);
        n_req.digits[1] = tcdd_pkg::seg_code(tcdd_pkg::ones_of(h_sat, h_tens))
                          | (r_colon ? tcdd_pkg::COLON_BIT : 8'h00);
        n_req.digits[2] = tcdd_pkg::seg_code(m_tens);
        n_req.digits[3] = tcdd_pkg::seg_code(tcdd_pkg::ones_of(m_sat, m_tens));
        n_req.bright    = r_bright;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bright <= tcdd_pkg::BRIGHT_RESET;
            r_colon  <= 1'b1;
            r_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    tcdd_pkg::REG_BRIGHTNESS: r_bright <= i_cfg_data;
                    tcdd_pkg::REG_COLON:      r_colon  <= i_cfg_data[0];
                    default:                  r_colon  <= r_colon;
                endcase
            end
            if (accept) begin
                r_valid <= 1'b1;
            end else if (o_push) begin
                r_valid <= 1'b0;
            end
        end
        if (accept) begin
            r_req <= n_req;
        end
    end

endmodule

// File: rtl/core/tcdd_queue.sv
// Two-entry queue between the classifying front and the pin sequencer.
module tcdd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tcdd_pkg::t_req i_req,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output tcdd_pkg::t_req o_req
);

    tcdd_pkg::t_req r_mem [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_req   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_req;
        end
    end

endmodule

// File: rtl/core/tcdd_back.sv
// Pin sequencer: steps the frame waveform one slot per tick and registers the pin levels.
module tcdd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  tcdd_pkg::t_req i_req,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output logic           o_clk_level,
    output logic           o_dio_level,
    output logic           o_dio_drive,
    output logic           o_busy_res
);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_START_A,
        PH_START_B,
        PH_BIT_LOW,
        PH_BIT_HIGH,
        PH_ACK_LOW,
        PH_ACK_HIGH,
        PH_STOP_A,
        PH_STOP_B,
        PH_STOP_C
    } t_phase;

    typedef enum logic [1:0] {
        K_NONE,
        K_MODE,
        K_DATA,
        K_BRIGHT
    } t_kind;

    t_phase                           r_phase;
    t_phase                           n_phase;
    t_kind                            r_kind;
    t_kind                            n_kind;
    logic [2:0]                       r_byte_idx;
    logic [2:0]                       n_byte_idx;
    logic [3:0]                       r_bit_idx;
    logic [3:0]                       n_bit_idx;
    logic [7:0]                       r_shift;
    logic [7:0]                       n_shift;
    logic [tcdd_pkg::DIGITS-1:0][7:0] r_digits;
    logic [tcdd_pkg::DIGITS-1:0][7:0] n_digits;
    logic                             r_out_valid;
    logic                             r_clk;
    logic                             r_dio;
    logic                             r_drv;
    logic                             r_busy;
    logic                             n_clk;
    logic                             n_dio;
    logic                             n_drv;
    logic                             n_busy;
    logic [1:0]                       digit_sel;

    assign o_pop       = !i_empty && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_clk_level = r_clk;
    assign o_dio_level = r_dio;
    assign o_dio_drive = r_drv;
    assign o_busy_res  = r_busy;

    always_comb begin
        n_phase    = r_phase;
        n_kind     = r_kind;
        n_byte_idx = r_byte_idx;
        n_bit_idx  = r_bit_idx;
        n_shift    = r_shift;
        n_digits   = r_digits;
        n_clk      = 1'b1;
        n_dio      = 1'b1;
        n_drv      = 1'b1;
        n_busy     = 1'b1;
        digit_sel  = 2'd0;

        if (r_phase == PH_IDLE) begin
            if (i_req.act == tcdd_pkg::ACT_TIME) begin
                n_digits   = i_req.digits;
                n_kind     = K_MODE;
                n_shift    = tcdd_pkg::CMD_DATA;
                n_byte_idx = 3'd0;
                n_phase    = PH_START_A;
            end else if (i_req.act == tcdd_pkg::ACT_BRIGHT) begin
                n_kind     = K_BRIGHT;
                n_shift    = tcdd_pkg::CMD_CTRL | {5'd0, i_req.bright};
                n_byte_idx = 3'd0;
                n_phase    = PH_START_A;
            end
        end

        unique case (n_phase)
            PH_START_A: begin
                n_phase = PH_START_B;
            end
            PH_START_B: begin
                n_dio     = 1'b0;
                n_bit_idx = 4'd0;
                n_phase   = PH_BIT_LOW;
            end
            PH_BIT_LOW: begin
                n_clk   = 1'b0;
                n_dio   = n_shift[0];
                n_phase = PH_BIT_HIGH;
            end
            PH_BIT_HIGH: begin
                n_dio     = n_shift[0];
                n_shift   = {1'b0, n_shift[7:1]};
                n_bit_idx = n_bit_idx + 4'd1;
                n_phase   = (n_bit_idx >= 4'd8) ? PH_ACK_LOW : PH_BIT_LOW;
            end
            PH_ACK_LOW: begin
                n_clk   = 1'b0;
                n_dio   = 1'b0;
                n_drv   = 1'b0;
                n_phase = PH_ACK_HIGH;
            end
            PH_ACK_HIGH: begin
                n_dio      = 1'b0;
                n_drv      = 1'b0;
                n_byte_idx = n_byte_idx + 3'd1;
                digit_sel  = 2'(n_byte_idx - 3'd1);
                if (n_kind == K_DATA && n_byte_idx >= 3'd1 && n_byte_idx <= 3'd4) begin
                    n_shift   = n_digits[digit_sel];
                    n_bit_idx = 4'd0;
                    n_phase   = PH_BIT_LOW;
                end else begin
                    n_phase = PH_STOP_A;
                end
            end
            PH_STOP_A: begin
                n_clk   = 1'b0;
                n_dio   = 1'b0;
                n_phase = PH_STOP_B;
            end
            PH_STOP_B: begin
                n_clk   = 1'b0;
                n_dio   = 1'b0;
                n_phase = PH_STOP_C;
            end
            PH_STOP_C: begin
                n_dio = 1'b0;
                if (n_kind == K_MODE) begin
                    n_kind     = K_DATA;
                    n_shift    = tcdd_pkg::CMD_ADDR;
                    n_byte_idx = 3'd0;
                    n_phase    = PH_START_A;
                end else begin
                    n_kind  = K_NONE;
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                n_busy  = 1'b0;
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_kind      <= K_NONE;
            r_byte_idx  <= 3'd0;
            r_bit_idx   <= 4'd0;
            r_shift     <= 8'd0;
            r_out_valid <= 1'b0;
            r_clk       <= 1'b1;
            r_dio       <= 1'b1;
            r_drv       <= 1'b1;
            r_busy      <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase     <= n_phase;
                r_kind      <= n_kind;
                r_byte_idx  <= n_byte_idx;
                r_bit_idx   <= n_bit_idx;
                r_shift     <= n_shift;
                r_digits    <= n_digits;
                r_out_valid <= 1'b1;
                r_clk       <= n_clk;
                r_dio       <= n_dio;
                r_drv       <= n_drv;
                r_busy      <= n_busy;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// File: rtl/core/two_wire_clock_display_driver_top.sv
// Top level of the two-wire seven-segment clock display driver.
// Every transferred input item is one delay tick and yields exactly one result holding the
// pin levels for that tick. The block takes one tick per clock cycle when neither side
// stalls; each tick passes through the input register, the two-entry queue and the
// output register of the pin sequencer before its result is presented.
// A time update sends two frames of 23 and 95 ticks; a brightness command sends one
// frame of 23 ticks. Requests that arrive during a frame sequence are ignored.
module two_wire_clock_display_driver_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [tcdd_pkg::BRIGHT_W-1:0] i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_action,
    input  logic [6:0]                    i_hours,
    input  logic [6:0]                    i_minutes,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_clk_level,
    output logic                          o_dio_level,
    output logic                          o_dio_drive,
    output logic                          o_busy_res
);

    logic           push;
    logic           pop;
    logic           q_full;
    logic           q_empty;
    tcdd_pkg::t_req front_req;
    tcdd_pkg::t_req back_req;

    tcdd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_action    (i_action),
        .i_hours     (i_hours),
        .i_minutes   (i_minutes),
        .o_push      (push),
        .o_req       (front_req),
        .i_q_full    (q_full)
    );

    tcdd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (front_req),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_req   (back_req)
    );

    tcdd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_req       (back_req),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_clk_level (o_clk_level),
        .o_dio_level (o_dio_level),
        .o_dio_drive (o_dio_drive),
        .o_busy_res  (o_busy_res)
    );

endmodule
